// ----- design/qte_pkg.sv -----
// Shared constants, types and helpers for the quaternion to Euler converter.
// Depends on nothing; every other design file imports it.
`default_nettype none
package qte_pkg;

  localparam int QW           = 16;  // input component width, Q1.15
  localparam int OPW          = 34;  // signed arctangent operand width
  localparam int NW           = 40;  // normalized magnitude width
  localparam int CW           = 43;  // CORDIC x/y width
  localparam int ZW           = 27;  // angle accumulator width, Q24
  localparam int PW           = 28;  // pitch angle width before rounding
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 27;
  localparam int RADW         = 54;  // radicand width, Q30 shifted left by 20
  localparam int SQW          = 27;  // square root result width
  localparam int NORM_PASSES  = 6;   // shift passes of 32,16,8,4,2,1

  localparam logic signed [ZW-1:0] PI_Q24       = 27'sd52707179;
  localparam logic signed [ZW-1:0] HALF_PI_Q24  = 27'sd26353589;
  localparam logic signed [PW-1:0] CODE_HALF_PI = 28'sd26353568;

  // atan(2^-i) in Q24, rounded to nearest
  localparam logic [23:0] ATAN_TAB [CORDIC_STEPS] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
    24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
  };

  typedef struct packed {
    logic zero_x;
    logic zero_y;
    logic neg_x;
    logic neg_y;
  } atan_flags_t;

  // Q24 to Q13, rounding half away from zero
  function automatic logic signed [15:0] round_q13(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    logic [PW-1:0] s;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    s = (m + PW'(1024)) >> 11;
    round_q13 = v[PW-1] ? -signed'(s[15:0]) : signed'(s[15:0]);
  endfunction

endpackage
`default_nettype wire

// ----- design/qte_sqrt_cell.sv -----
// One bit of a pipelined restoring integer square root.
// Depends on qte_pkg.
`default_nettype none
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [qte_pkg::RADW-1:0] n_in,
  input  wire logic [qte_pkg::RADW-1:0] res_in,
  output logic      [qte_pkg::RADW-1:0] n_out,
  output logic      [qte_pkg::RADW-1:0] res_out
);
  import qte_pkg::*;

  localparam logic [RADW-1:0] BIT = RADW'(1) << (2 * K);

  logic [RADW-1:0] trial;
  assign trial = res_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= trial) begin
        n_out   <= n_in - trial;
        res_out <= (res_in >> 1) + BIT;
      end else begin
        n_out   <= n_in;
        res_out <= res_in >> 1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/qte_cordic_cell.sv -----
// One vectoring-mode CORDIC rotation with its angle accumulation.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [qte_pkg::CW-1:0] cx_in,
  input  wire logic signed [qte_pkg::CW-1:0] cy_in,
  input  wire logic signed [qte_pkg::ZW-1:0] z_in,
  input  wire qte_pkg::atan_flags_t          f_in,
  output logic signed      [qte_pkg::CW-1:0] cx_out,
  output logic signed      [qte_pkg::CW-1:0] cy_out,
  output logic signed      [qte_pkg::ZW-1:0] z_out,
  output qte_pkg::atan_flags_t               f_out
);
  import qte_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] ang;

  assign dx  = cy_in >>> STEP;
  assign dy  = cx_in >>> STEP;
  assign ang = signed'({{(ZW-24){1'b0}}, ATAN_TAB[STEP]});

  always_ff @(posedge clk) begin
    if (en) begin
      f_out <= f_in;
      if (cy_in > 0) begin
        cx_out <= cx_in + dx;
        cy_out <= cy_in - dy;
        z_out  <= z_in + ang;
      end else begin
        cx_out <= cx_in - dx;
        cy_out <= cy_in + dy;
        z_out  <= z_in - ang;
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/qte_atan.sv -----
// Four-quadrant arctangent: normalize stage, row of CORDIC cells, fold stage.
// Depends on qte_pkg and qte_cordic_cell.
`default_nettype none
module qte_atan (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [qte_pkg::OPW-1:0] y_in,
  input  wire logic signed [qte_pkg::OPW-1:0] x_in,
  output logic signed      [qte_pkg::ZW-1:0]  z_out
);
  import qte_pkg::*;

  logic [OPW-1:0] ax;
  logic [OPW-1:0] ay;
  logic [NW-1:0]  nx;
  logic [NW-1:0]  ny;
  logic [NW-1:0]  nm;

  assign ax = x_in[OPW-1] ? OPW'(-x_in) : OPW'(x_in);
  assign ay = y_in[OPW-1] ? OPW'(-y_in) : OPW'(y_in);

  // scale both until the larger magnitude reaches 2^39
  always_comb begin
    int sh;
    nx = NW'(ax);
    ny = NW'(ay);
    nm = (ax > ay) ? NW'(ax) : NW'(ay);
    for (int i = 0; i < NORM_PASSES; i++) begin
      sh = 32 >> i;
      if (nm < (NW'(1) << (NW - sh))) begin
        nm = nm << sh;
        nx = nx << sh;
        ny = ny << sh;
      end
    end
  end

  logic signed [CW-1:0] cx [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  atan_flags_t          cf [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= signed'(CW'(nx));
      cy[0] <= signed'(CW'(ny));
      cz[0] <= '0;
      cf[0] <= '{zero_x: (ax == '0), zero_y: (ay == '0),
                 neg_x: x_in[OPW-1], neg_y: y_in[OPW-1]};
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    qte_cordic_cell #(.STEP(g)) u_cell (
      .clk    (clk),
      .en     (en),
      .cx_in  (cx[g]),
      .cy_in  (cy[g]),
      .z_in   (cz[g]),
      .f_in   (cf[g]),
      .cx_out (cx[g+1]),
      .cy_out (cy[g+1]),
      .z_out  (cz[g+1]),
      .f_out  (cf[g+1])
    );
  end

  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] zf;
  atan_flags_t          fl;

  assign fl = cf[CORDIC_STEPS];

  always_comb begin
    zc = cz[CORDIC_STEPS];
    if (zc < 0) begin
      zc = '0;
    end else if (zc > HALF_PI_Q24) begin
      zc = HALF_PI_Q24;
    end
    if (fl.zero_x && fl.zero_y) begin
      zf = '0;
    end else begin
      if (fl.zero_y) begin
        zf = '0;
      end else if (fl.zero_x) begin
        zf = HALF_PI_Q24;
      end else begin
        zf = zc;
      end
      if (fl.neg_x) begin
        zf = PI_Q24 - zf;
      end
      if (fl.neg_y) begin
        zf = -zf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_out <= zf;
    end
  end
endmodule
`default_nettype wire

// ----- design/quaternion_to_euler_angles.sv -----
// Quaternion (Q1.15) to roll, pitch, yaw (Q3.13 radians), fully pipelined.
// Stages: products, sums, 27 square root cells, normalize, 24 CORDIC cells,
// fold, output register. Throughput: one request per cycle while the skid
// entry is empty; a two-entry output stage lets the pipe keep taking requests
// while a result waits. Reset clears valid bits only.
// Depends on qte_pkg, qte_sqrt_cell, qte_atan, qte_cordic_cell.
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], 0
);
  import qte_pkg::*;

  localparam int ATAN_LAT = CORDIC_STEPS + 2;
  localparam int DEPTH    = 2 + SQRT_STEPS + ATAN_LAT;

  // Whole pipe advances together; stall only when the skid entry is taken.
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  // valid line alongside the data
  logic [DEPTH-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // Stage 1: the nine component products
  logic signed [QW-1:0] qw, qx, qy, qz;
  assign qw = signed'(s_tdata[15:0]);
  assign qx = signed'(s_tdata[31:16]);
  assign qy = signed'(s_tdata[47:32]);
  assign qz = signed'(s_tdata[63:48]);

  logic signed [2*QW-1:0] p_wx, p_yz, p_xx, p_yy, p_zz, p_wz, p_xy, p_wy, p_xz;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_wy <= qw * qy;
      p_xz <= qx * qz;
    end
  end

  // Stage 2: arctangent operands and clamped pitch radicands
  logic signed [OPW+1:0] sr_w, cr_w, sy_w, cy_w, t_w, a_w, b_w;
  always_comb begin
    sr_w = 36'sd2 * (36'(p_wx) + 36'(p_yz));
    cr_w = (36'sd1 <<< 30) - 36'sd2 * (36'(p_xx) + 36'(p_yy));
    sy_w = 36'sd2 * (36'(p_wz) + 36'(p_xy));
    cy_w = (36'sd1 <<< 30) - 36'sd2 * (36'(p_yy) + 36'(p_zz));
    t_w  = 36'sd2 * (36'(p_wy) - 36'(p_xz));
    a_w  = (36'sd1 <<< 30) + t_w;
    b_w  = (36'sd1 <<< 30) - t_w;
  end

  logic signed [OPW-1:0] d_sr [SQRT_STEPS+1];
  logic signed [OPW-1:0] d_cr [SQRT_STEPS+1];
  logic signed [OPW-1:0] d_sy [SQRT_STEPS+1];
  logic signed [OPW-1:0] d_cy [SQRT_STEPS+1];
  logic [RADW-1:0]       ra_n [SQRT_STEPS+1];
  logic [RADW-1:0]       ra_r [SQRT_STEPS+1];
  logic [RADW-1:0]       rb_n [SQRT_STEPS+1];
  logic [RADW-1:0]       rb_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_sr[0] <= OPW'(sr_w);
      d_cr[0] <= OPW'(cr_w);
      d_sy[0] <= OPW'(sy_w);
      d_cy[0] <= OPW'(cy_w);
      // drop negative radicands to zero, then scale to Q50
      ra_n[0] <= a_w[OPW+1] ? '0 : (RADW'(a_w) << 20);
      rb_n[0] <= b_w[OPW+1] ? '0 : (RADW'(b_w) << 20);
      ra_r[0] <= '0;
      rb_r[0] <= '0;
    end
  end

  // Square root cells, most significant result bit first; hold roll/yaw alongside
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    qte_sqrt_cell #(.K(SQRT_STEPS - 1 - g)) u_sa (
      .clk (clk), .en (en),
      .n_in (ra_n[g]), .res_in (ra_r[g]), .n_out (ra_n[g+1]), .res_out (ra_r[g+1])
    );
    qte_sqrt_cell #(.K(SQRT_STEPS - 1 - g)) u_sb (
      .clk (clk), .en (en),
      .n_in (rb_n[g]), .res_in (rb_r[g]), .n_out (rb_n[g+1]), .res_out (rb_r[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        d_sr[g+1] <= d_sr[g];
        d_cr[g+1] <= d_cr[g];
        d_sy[g+1] <= d_sy[g];
        d_cy[g+1] <= d_cy[g];
      end
    end
  end

  logic signed [OPW-1:0] sa_op;
  logic signed [OPW-1:0] sb_op;
  assign sa_op = signed'(OPW'(ra_r[SQRT_STEPS][SQW-1:0]));
  assign sb_op = signed'(OPW'(rb_r[SQRT_STEPS][SQW-1:0]));

  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;

  qte_atan u_roll (
    .clk (clk), .en (en), .y_in (d_sr[SQRT_STEPS]), .x_in (d_cr[SQRT_STEPS]), .z_out (z_roll)
  );
  qte_atan u_pitch (
    .clk (clk), .en (en), .y_in (sa_op), .x_in (sb_op), .z_out (z_pitch)
  );
  qte_atan u_yaw (
    .clk (clk), .en (en), .y_in (d_sy[SQRT_STEPS]), .x_in (d_cy[SQRT_STEPS]), .z_out (z_yaw)
  );

  // Round to Q13; pitch is twice its angle less the half-pi offset
  logic signed [PW-1:0] pitch_q24;
  logic signed [15:0]   roll_r, pitch_r, yaw_r;
  logic [47:0]          pipe_data;
  logic                 pipe_valid;

  assign pitch_q24  = (PW'(z_pitch) <<< 1) - CODE_HALF_PI;
  assign roll_r     = round_q13(PW'(z_roll));
  assign pitch_r    = round_q13(pitch_q24);
  assign yaw_r      = round_q13(PW'(z_yaw));
  assign pipe_data  = {1'b0, yaw_r, pitch_r[14:0], roll_r};
  assign pipe_valid = vld[DEPTH-1];

  // Output register plus one skid entry
  logic [47:0] skid_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || pipe_valid;
      skid_valid <= 1'b0;
    end else if (pipe_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : pipe_data;
    end else if (pipe_valid && !skid_valid) begin
      skid_data <= pipe_data;
    end
  end

  // a filled skid entry always sits behind a shown result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> m_tvalid)
    else $error("skid entry held with no result shown");

  // skid only fills when the shown result was stalled
  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without a stall");

  // a stalled result with a full skid keeps the input side closed
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && skid_valid) |=> !s_tready)
    else $error("input opened while both output entries are full");

  // pitch stays within plus or minus half pi
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868 &&
                  $signed(m_tdata[30:16]) >= -15'sd12868))
    else $error("pitch out of range");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Regression bench for quaternion_to_euler_angles: random and corner quaternions
// are streamed in, results are predicted in-bench and compared field by field.
// Depends on the DUT only.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // roll[15:0], pitch[30:16], yaw[46:31], 0

  typedef struct packed {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
  } angles_t;

  localparam longint ONE_Q30   = 64'sd1 << 30;
  localparam longint PI_Q24    = 64'sd52707179;
  localparam longint HPI_Q24   = 64'sd26353589;
  localparam longint PITCH_OFS = 64'sd26353568;
  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  angles_t angles_due[$];
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      hold_off;
  int      failures;

  quaternion_to_euler_angles DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;   // arithmetic shift is a floor division
  endfunction

  // four-quadrant arctangent, Q24 result
  function automatic longint atan2_q24(longint y, longint x);
    longint ax, ay, m, cx, cy, dx, dy, z;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    z = 0;
    if (ax == 0 && ay == 0) return 0;
    if (ay == 0) z = 0;
    else if (ax == 0) z = HPI_Q24;
    else begin
      m = (ax > ay) ? ax : ay;
      while (m < (64'sd1 << 39)) begin
        ax = ax <<< 1; ay = ay <<< 1; m = m <<< 1;
      end
      cx = ax; cy = ay;
      for (int i = 0; i < 24; i++) begin
        dx = floor_shr(cy, i);
        dy = floor_shr(cx, i);
        if (cy > 0) begin
          cx += dx; cy -= dy; z += ATAN_Q24[i];
        end else begin
          cx -= dx; cy += dy; z -= ATAN_Q24[i];
        end
      end
      if (z < 0) z = 0;
      if (z > HPI_Q24) z = HPI_Q24;
    end
    if (x < 0) z = PI_Q24 - z;
    if (y < 0) z = -z;
    return z;
  endfunction

  function automatic longint to_q13(longint v);
    return (v >= 0) ? ((v + 1024) >>> 11) : -((-v + 1024) >>> 11);
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >>> 1) + b;
      end else r = r >>> 1;
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    longint w, x, y, z, t, a, b;
    angles_t e;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    e.roll = 16'(to_q13(atan2_q24(2 * (w * x + y * z), ONE_Q30 - 2 * (x * x + y * y))));
    t = 2 * (w * y - x * z);
    a = ONE_Q30 + t;
    b = ONE_Q30 - t;
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    e.pitch = 15'(to_q13(2 * atan2_q24(floor_sqrt(a <<< 20), floor_sqrt(b <<< 20))
                         - PITCH_OFS));
    e.yaw = 16'(to_q13(atan2_q24(2 * (w * z + x * y), ONE_Q30 - 2 * (y * y + z * z))));
    return e;
  endfunction

  // Offer one request, with a random idle gap first; hold until accepted.
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x, w};
    angles_due.push_back(euler_of({z, y, x, w}));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver stalls at random, or for a long stretch when hold_off is set.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    angles_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[30:16], m_tdata[46:31]};
      if (angles_due.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        failures++;
      end else begin
        want = angles_due.pop_front();
        if (got.roll !== want.roll) begin
          $error("roll_angle expected %0d got %0d", $signed(want.roll), $signed(got.roll));
          failures++;
        end
        if (got.pitch !== want.pitch) begin
          $error("pitch_angle expected %0d got %0d", $signed(want.pitch),
                 $signed(got.pitch));
          failures++;
        end
        if (got.yaw !== want.yaw) begin
          $error("yaw_angle expected %0d got %0d", $signed(want.yaw), $signed(got.yaw));
          failures++;
        end
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    return 16'($urandom_range(65534) - 32767);
  endfunction

  // Corners: identity, axis turns, gimbal lock, extremes, unnormalized, -32768.
  task automatic test_corners();
    send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000);   // pitch +90
    send_quat(16'h5A82, 16'h0000, 16'hA57E, 16'h0000);   // pitch -90
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);   // pitch radicands equal
    send_quat(16'h7FFF, 16'h8001, 16'h7FFF, 16'h8001);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8001, 16'h8001, 16'h8001, 16'h8001);
    send_quat(16'h8000, 16'h7FFF, 16'h0000, 16'h8000);
    send_quat(16'h0000, 16'h8001, 16'h0000, 16'h0000);   // x operand negative
    send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
    send_quat(16'h4000, 16'hC000, 16'h4000, 16'hC000);
    send_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
  endtask

  // Mostly unit quaternions with random direction, some raw noise.
  task automatic test_random(int n);
    real a, b, c, d, s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      else begin
        a = real'($signed(rand_comp())); b = real'($signed(rand_comp()));
        c = real'($signed(rand_comp())); d = real'($signed(rand_comp()));
        s = $sqrt(a * a + b * b + c * c + d * d);
        if (s < 1.0) s = 1.0;
        s = 32767.0 / s;
        send_quat(16'($rtoi(a * s)), 16'($rtoi(b * s)), 16'($rtoi(c * s)),
                  16'($rtoi(d * s)));
      end
    end
  endtask

  // Block the output long enough that the pipe fills and stalls the input.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(100);
    join
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    hold_off = 1'b0;
    failures = 0;
    send_idle_pct = 12;
    recv_idle_pct = 76;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corners();
    test_random(350);
    send_idle_pct = 76;
    recv_idle_pct = 12;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(330);
    drain();
    if (failures == 0) $display("quaternion_to_euler_angles regression: pass");
    else $display("quaternion_to_euler_angles regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("quaternion_to_euler_angles regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
